@@ rtl/core/ffa_pkg.sv @@
// Shared types and constants for the first-fit free list allocator.
// No dependencies; imported by ffa_ctrl, ffa_dp and the top level.
package ffa_pkg;

    localparam int unsigned ADDR_W = 17;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [16:0] GROW_RESET = 17'd4096;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [5:0] {
        C_NOP,
        C_INIT,
        C_LOAD,
        C_RD_HDR,
        C_WALK_HIT,
        C_RD_NEXT,
        C_CAP_BP,
        C_GROW_CALC,
        C_GROW_TAG,
        C_GROW_EPI,
        C_RD_PFTR,
        C_CAP_PFTR,
        C_CAP_NHDR,
        C_M_NEXT,
        C_M_PREV,
        C_M_BOTH,
        C_SET_UB_NB,
        C_M_TAG,
        C_PUSH_BP,
        C_MERGED,
        C_UB_FOUND,
        C_TAG_A,
        C_TAG_C,
        C_TAG_R,
        C_PUSH_R,
        C_FREE_TAG,
        C_ADV,
        C_TAG_H,
        C_TAG_F,
        C_PU_NX,
        C_PU_PV,
        C_PU_BK,
        C_RD_UB,
        C_CAP_NX,
        C_UN_FIX,
        C_UN_BK,
        C_RES_OK,
        C_RES_OOM,
        C_RES_ZERO
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic func;
        logic req_zero;
        logic bp_zero;
        logic fit;
        logic rd_zero;
        logic rd_alloc;
        logic bp_lt_he;
        logic bp_gt_addr;
        logic bp_eq_addr;
        logic pa;
        logic na;
        logic split;
        logic ovf;
        logic out_busy;
    } t_stat;

endpackage

@@ rtl/core/ffa_if.sv @@
// Handshake channel interfaces for allocator requests and responses.
// Depends on nothing; used by the top level.
interface ffa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] request_bytes;
    logic [15:0] block_addr;
    modport source (output valid, func, request_bytes, block_addr, input ready);
    modport sink   (input valid, func, request_bytes, block_addr, output ready);
endinterface

interface ffa_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_addr;
    logic [1:0]  status;
    modport source (output valid, payload_addr, status, input ready);
    modport sink   (input valid, payload_addr, status, output ready);
endinterface

@@ rtl/core/ffa_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module ffa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/ffa_ctrl.sv @@
// Sequencer for allocate and free: walks, merges, tag and link updates.
// Depends on ffa_pkg; drives ffa_dp through one command per cycle.
module ffa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ffa_pkg::t_stat i_stat,
    output ffa_pkg::t_cmd  o_cmd
);
    import ffa_pkg::*;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_DISP,
        S_WALK_RD, S_WALK_CHK, S_WALK_NX,
        S_GROW, S_GROW_CHK, S_GROW_EPI,
        S_M0, S_M1, S_M2, S_M3, S_M_UN2, S_M_TAG, S_M_PUSH, S_M_END,
        S_PLACE, S_P1, S_P2, S_P3,
        S_F0, S_F1,
        S_T0, S_T1,
        S_PU0, S_PU1, S_PU2,
        S_U0, S_U1, S_U2, S_U3,
        S_RES_OK, S_RES_OOM, S_RES_ZERO
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        w_cmd   = C_NOP;
        case (r_state)
            S_INIT: begin
                w_cmd = C_INIT;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd   = C_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.func)          n_state = S_F0;
                else if (i_stat.req_zero) n_state = S_RES_ZERO;
                else                      n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (i_stat.bp_zero) begin
                    n_state = S_GROW;
                end else begin
                    w_cmd   = C_RD_HDR;
                    n_state = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (i_stat.fit) begin
                    w_cmd   = C_WALK_HIT;
                    n_state = S_PLACE;
                end else begin
                    w_cmd   = C_RD_NEXT;
                    n_state = S_WALK_NX;
                end
            end
            S_WALK_NX: begin
                w_cmd   = C_CAP_BP;
                n_state = S_WALK_RD;
            end
            S_GROW: begin
                w_cmd   = C_GROW_CALC;
                n_state = S_GROW_CHK;
            end
            S_GROW_CHK: begin
                if (i_stat.ovf) begin
                    n_state = S_RES_OOM;
                end else begin
                    w_cmd   = C_GROW_TAG;
                    n_ret   = S_GROW_EPI;
                    n_state = S_T0;
                end
            end
            S_GROW_EPI: begin
                w_cmd   = C_GROW_EPI;
                n_state = S_M0;
            end
            S_M0: begin
                w_cmd   = C_RD_PFTR;
                n_state = S_M1;
            end
            S_M1: begin
                w_cmd   = C_CAP_PFTR;
                n_state = S_M2;
            end
            S_M2: begin
                w_cmd   = C_CAP_NHDR;
                n_state = S_M3;
            end
            S_M3: begin
                // four coalescing cases on the neighbor alloc bits
                if (i_stat.pa && i_stat.na) begin
                    n_state = S_M_PUSH;
                end else if (i_stat.pa) begin
                    w_cmd   = C_M_NEXT;
                    n_ret   = S_M_TAG;
                    n_state = S_U0;
                end else if (i_stat.na) begin
                    w_cmd   = C_M_PREV;
                    n_ret   = S_M_TAG;
                    n_state = S_U0;
                end else begin
                    w_cmd   = C_M_BOTH;
                    n_ret   = S_M_UN2;
                    n_state = S_U0;
                end
            end
            S_M_UN2: begin
                w_cmd   = C_SET_UB_NB;
                n_ret   = S_M_TAG;
                n_state = S_U0;
            end
            S_M_TAG: begin
                w_cmd   = C_M_TAG;
                n_ret   = S_M_PUSH;
                n_state = S_T0;
            end
            S_M_PUSH: begin
                w_cmd   = C_PUSH_BP;
                n_ret   = S_M_END;
                n_state = S_PU0;
            end
            S_M_END: begin
                if (i_stat.func) begin
                    n_state = S_RES_OK;
                end else begin
                    w_cmd   = C_MERGED;
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                w_cmd   = C_UB_FOUND;
                n_ret   = S_P1;
                n_state = S_U0;
            end
            S_P1: begin
                if (i_stat.split) begin
                    w_cmd = C_TAG_A;
                    n_ret = S_P2;
                end else begin
                    w_cmd = C_TAG_C;
                    n_ret = S_RES_OK;
                end
                n_state = S_T0;
            end
            S_P2: begin
                w_cmd   = C_TAG_R;
                n_ret   = S_P3;
                n_state = S_T0;
            end
            S_P3: begin
                w_cmd   = C_PUSH_R;
                n_ret   = S_RES_OK;
                n_state = S_PU0;
            end
            S_F0: begin
                if (!i_stat.bp_lt_he || i_stat.bp_gt_addr) begin
                    n_state = S_RES_OK;
                end else begin
                    w_cmd   = C_RD_HDR;
                    n_state = S_F1;
                end
            end
            S_F1: begin
                if (i_stat.rd_zero) begin
                    n_state = S_RES_OK;
                end else if (i_stat.bp_eq_addr) begin
                    if (i_stat.rd_alloc) begin
                        w_cmd   = C_FREE_TAG;
                        n_ret   = S_M0;
                        n_state = S_T0;
                    end else begin
                        n_state = S_RES_OK;
                    end
                end else begin
                    w_cmd   = C_ADV;
                    n_state = S_F0;
                end
            end
            S_T0: begin
                w_cmd   = C_TAG_H;
                n_state = S_T1;
            end
            S_T1: begin
                w_cmd   = C_TAG_F;
                n_state = r_ret;
            end
            S_PU0: begin
                w_cmd   = C_PU_NX;
                n_state = S_PU1;
            end
            S_PU1: begin
                w_cmd   = C_PU_PV;
                n_state = S_PU2;
            end
            S_PU2: begin
                w_cmd   = C_PU_BK;
                n_state = r_ret;
            end
            S_U0: begin
                w_cmd   = C_RD_UB;
                n_state = S_U1;
            end
            S_U1: begin
                w_cmd   = C_CAP_NX;
                n_state = S_U2;
            end
            S_U2: begin
                w_cmd   = C_UN_FIX;
                n_state = S_U3;
            end
            S_U3: begin
                w_cmd   = C_UN_BK;
                n_state = r_ret;
            end
            S_RES_OK: begin
                if (!i_stat.out_busy) begin
                    w_cmd   = C_RES_OK;
                    n_state = S_IDLE;
                end
            end
            S_RES_OOM: begin
                if (!i_stat.out_busy) begin
                    w_cmd   = C_RES_OOM;
                    n_state = S_IDLE;
                end
            end
            S_RES_ZERO: begin
                if (!i_stat.out_busy) begin
                    w_cmd   = C_RES_ZERO;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

    a_load_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_LOAD) |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_RES_OK || w_cmd == C_RES_OOM || w_cmd == C_RES_ZERO)
        |=> o_in_ready)
        else $error("no return to idle after result");
    a_no_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.out_busy |-> !(w_cmd == C_RES_OK || w_cmd == C_RES_OOM
                              || w_cmd == C_RES_ZERO))
        else $error("result issued over a pending response");
endmodule

@@ rtl/core/ffa_dp.sv @@
// Allocator datapath: heap RAM, pointer and size registers, response register.
// Depends on ffa_pkg and ffa_ram; executes one ffa_ctrl command per cycle.
module ffa_dp #(
    parameter int unsigned HEAP_BYTES       = 65536,
    parameter int unsigned INIT_CHUNK_BYTES = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ffa_pkg::t_cmd  i_cmd,
    output ffa_pkg::t_stat o_stat,
    input  logic           i_cfg_we,
    input  logic [16:0]    i_cfg_data,
    input  logic           i_func,
    input  logic [15:0]    i_request_bytes,
    input  logic [15:0]    i_block_addr,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_payload_addr,
    output logic [1:0]     o_status
);
    import ffa_pkg::*;

    localparam int unsigned TOP_I   = ((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536) / 8 * 8;
    localparam int unsigned WORDS   = TOP_I / 4;
    localparam int unsigned AW      = $clog2(WORDS);
    localparam int unsigned C0      = ((INIT_CHUNK_BYTES / 4 + 1) / 2) * 8;
    localparam int unsigned CHUNK_I = (16 + C0 > TOP_I) ? TOP_I - 16 : C0;
    localparam t_addr       CHUNK   = t_addr'(CHUNK_I);
    localparam logic [18:0] TOP     = 19'(TOP_I);

    // control state
    logic [2:0]  r_icnt, n_icnt;
    t_addr       r_fh, n_fh;
    t_addr       r_he, n_he;
    logic [16:0] r_grow;
    logic        r_ovalid, n_ovalid;
    // working registers
    logic        r_func, n_func;
    logic [15:0] r_req, n_req;
    logic [15:0] r_addr, n_addr;
    t_addr       r_asize, n_asize, r_bp, n_bp, r_size, n_size, r_nb, n_nb;
    t_addr       r_psz, n_psz, r_nsz, n_nsz, r_found, n_found, r_csize, n_csize;
    t_addr       r_nx, n_nx, r_pv, n_pv, r_ub, n_ub, r_tb, n_tb, r_ts, n_ts, r_pu, n_pu;
    logic        r_ta, n_ta, r_pa, n_pa, r_na, n_na;
    logic [17:0] r_ext, n_ext;
    logic [15:0] r_opay, n_opay;
    logic [1:0]  r_ost, n_ost;

    logic          w_re, w_we;
    t_addr         w_rb, w_wb;
    logic [31:0]   w_wdata, w_rdata;
    t_addr         w_rsz, w_rlink, w_m;
    logic [15:0]   w_r8;

    // request size plus 8 bytes of overhead, rounded up, in units of 8 bytes
    function automatic logic [13:0] w_req15_in(input logic [15:0] req);
        logic [16:0] s;
        s = {1'b0, req} + 17'd15;
        return s[16:3];
    endfunction

    ffa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_heap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_wb[AW+1:2]),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_rb[AW+1:2]),
        .o_rdata(w_rdata)
    );

    assign w_rsz   = {w_rdata[16:3], 3'b000};
    assign w_rlink = w_rdata[16:0];
    assign w_m     = (r_asize > r_grow) ? r_asize : r_grow;
    assign w_r8    = {1'b0, w_m[16:2]} + 16'd1;

    always_comb begin
        n_icnt = r_icnt;  n_fh = r_fh;  n_he = r_he;
        n_ovalid = r_ovalid && !i_ready;
        n_func = r_func;  n_req = r_req;  n_addr = r_addr;
        n_asize = r_asize; n_bp = r_bp; n_size = r_size; n_nb = r_nb;
        n_psz = r_psz; n_nsz = r_nsz; n_found = r_found; n_csize = r_csize;
        n_nx = r_nx; n_pv = r_pv; n_ub = r_ub; n_tb = r_tb; n_ts = r_ts;
        n_pu = r_pu; n_ta = r_ta; n_pa = r_pa; n_na = r_na; n_ext = r_ext;
        n_opay = r_opay; n_ost = r_ost;
        w_re = 1'b0; w_rb = '0; w_we = 1'b0; w_wb = '0; w_wdata = '0;
        case (i_cmd)
            C_INIT: begin
                w_we   = 1'b1;
                n_icnt = r_icnt + 3'd1;
                case (r_icnt)
                    3'd0: begin w_wb = t_addr'(4);  w_wdata = 32'd9; end
                    3'd1: begin w_wb = t_addr'(8);  w_wdata = 32'd9; end
                    3'd2: begin w_wb = t_addr'(12); w_wdata = {15'b0, CHUNK}; end
                    3'd3: begin w_wb = t_addr'(16); w_wdata = '0; end
                    3'd4: begin w_wb = t_addr'(20); w_wdata = '0; end
                    3'd5: begin w_wb = CHUNK + t_addr'(8); w_wdata = {15'b0, CHUNK}; end
                    3'd6: begin w_wb = CHUNK + t_addr'(12); w_wdata = 32'd1; end
                    default: w_we = 1'b0;
                endcase
            end
            C_LOAD: begin
                n_func  = i_func;
                n_req   = i_request_bytes;
                n_addr  = i_block_addr;
                n_asize = (i_request_bytes <= 16'd8) ? t_addr'(16)
                        : {w_req15_in(i_request_bytes), 3'b000};
                n_bp    = i_func ? t_addr'(16) : r_fh;
            end
            C_RD_HDR:   begin w_re = 1'b1; w_rb = r_bp - t_addr'(4); end
            C_WALK_HIT: begin n_found = r_bp; n_csize = w_rsz; end
            C_RD_NEXT:  begin w_re = 1'b1; w_rb = r_bp; end
            C_CAP_BP:   n_bp = w_rlink;
            C_GROW_CALC: n_ext = {w_r8[15:1], 3'b000};
            C_GROW_TAG: begin
                n_tb = r_he; n_ts = r_ext[16:0]; n_ta = 1'b0;
                n_bp = r_he; n_size = r_ext[16:0];
            end
            C_GROW_EPI: begin
                w_we    = 1'b1;
                w_wb    = r_he + r_ext[16:0] - t_addr'(4);
                w_wdata = 32'd1;
                n_he    = r_he + r_ext[16:0];
            end
            C_RD_PFTR: begin w_re = 1'b1; w_rb = r_bp - t_addr'(8); end
            C_CAP_PFTR: begin
                n_pa = w_rdata[0];
                n_psz = w_rsz;
                n_nb = r_bp + r_size;
                w_re = 1'b1;
                w_rb = r_bp + r_size - t_addr'(4);
            end
            C_CAP_NHDR: begin n_na = w_rdata[0]; n_nsz = w_rsz; end
            C_M_NEXT: begin n_size = r_size + r_nsz; n_ub = r_nb; end
            C_M_PREV: begin
                n_size = r_size + r_psz;
                n_bp = r_bp - r_psz;
                n_ub = r_bp - r_psz;
            end
            C_M_BOTH: begin
                n_size = r_size + r_psz + r_nsz;
                n_bp = r_bp - r_psz;
                n_ub = r_bp - r_psz;
            end
            C_SET_UB_NB: n_ub = r_nb;
            C_M_TAG:   begin n_tb = r_bp; n_ts = r_size; n_ta = 1'b0; end
            C_PUSH_BP: n_pu = r_bp;
            C_MERGED:  begin n_found = r_bp; n_csize = r_size; end
            C_UB_FOUND: n_ub = r_found;
            C_TAG_A: begin n_tb = r_found; n_ts = r_asize; n_ta = 1'b1; end
            C_TAG_C: begin n_tb = r_found; n_ts = r_csize; n_ta = 1'b1; end
            C_TAG_R: begin
                n_tb = r_found + r_asize; n_ts = r_csize - r_asize; n_ta = 1'b0;
            end
            C_PUSH_R: n_pu = r_found + r_asize;
            C_FREE_TAG: begin
                n_size = w_rsz; n_tb = r_bp; n_ts = w_rsz; n_ta = 1'b0;
            end
            C_ADV: n_bp = r_bp + w_rsz;
            C_TAG_H: begin
                w_we = 1'b1; w_wb = r_tb - t_addr'(4);
                w_wdata = {15'b0, r_ts} | {31'b0, r_ta};
            end
            C_TAG_F: begin
                w_we = 1'b1; w_wb = r_tb + r_ts - t_addr'(8);
                w_wdata = {15'b0, r_ts} | {31'b0, r_ta};
            end
            C_PU_NX: begin w_we = 1'b1; w_wb = r_pu; w_wdata = {15'b0, r_fh}; end
            C_PU_PV: begin w_we = 1'b1; w_wb = r_pu + t_addr'(4); w_wdata = '0; end
            C_PU_BK: begin
                w_we = (r_fh != '0); w_wb = r_fh + t_addr'(4);
                w_wdata = {15'b0, r_pu};
                n_fh = r_pu;
            end
            C_RD_UB: begin w_re = 1'b1; w_rb = r_ub; end
            C_CAP_NX: begin n_nx = w_rlink; w_re = 1'b1; w_rb = r_ub + t_addr'(4); end
            C_UN_FIX: begin
                n_pv = w_rlink;
                if (w_rlink == '0) begin
                    n_fh = r_nx;
                end else begin
                    w_we = 1'b1; w_wb = w_rlink; w_wdata = {15'b0, r_nx};
                end
            end
            C_UN_BK: begin
                w_we = (r_nx != '0); w_wb = r_nx + t_addr'(4);
                w_wdata = {15'b0, r_pv};
            end
            C_RES_OK: begin
                n_ovalid = 1'b1; n_ost = ST_OK;
                n_opay = r_func ? 16'd0 : r_found[15:0];
            end
            C_RES_OOM:  begin n_ovalid = 1'b1; n_ost = ST_OOM;  n_opay = '0; end
            C_RES_ZERO: begin n_ovalid = 1'b1; n_ost = ST_ZERO; n_opay = '0; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icnt   <= '0;
            r_fh     <= t_addr'(16);
            r_he     <= t_addr'(16) + CHUNK;
            r_grow   <= GROW_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_icnt   <= n_icnt;
            r_fh     <= n_fh;
            r_he     <= n_he;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_grow <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_req <= n_req;  r_addr <= n_addr;
        r_asize <= n_asize; r_bp <= n_bp; r_size <= n_size; r_nb <= n_nb;
        r_psz <= n_psz; r_nsz <= n_nsz; r_found <= n_found; r_csize <= n_csize;
        r_nx <= n_nx; r_pv <= n_pv; r_ub <= n_ub; r_tb <= n_tb; r_ts <= n_ts;
        r_pu <= n_pu; r_ta <= n_ta; r_pa <= n_pa; r_na <= n_na; r_ext <= n_ext;
        r_opay <= n_opay; r_ost <= n_ost;
    end

    assign o_stat.init_last  = (r_icnt == 3'd6);
    assign o_stat.func       = r_func;
    assign o_stat.req_zero   = (r_req == '0);
    assign o_stat.bp_zero    = (r_bp == '0);
    assign o_stat.fit        = (w_rsz >= r_asize);
    assign o_stat.rd_zero    = (w_rsz == '0);
    assign o_stat.rd_alloc   = w_rdata[0];
    assign o_stat.bp_lt_he   = (r_bp < r_he);
    assign o_stat.bp_gt_addr = (r_bp > {1'b0, r_addr});
    assign o_stat.bp_eq_addr = (r_bp == {1'b0, r_addr});
    assign o_stat.pa         = r_pa;
    assign o_stat.na         = r_na;
    assign o_stat.split      = ((r_csize - r_asize) >= t_addr'(16));
    assign o_stat.ovf        = (({2'b0, r_he} + {1'b0, r_ext}) > TOP);
    assign o_stat.out_busy   = r_ovalid && !i_ready;

    assign o_valid        = r_ovalid;
    assign o_payload_addr = r_opay;
    assign o_status       = r_ost;

    a_he_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b0, r_he} <= TOP) && (r_he[2:0] == 3'b000))
        else $error("heap end out of range or misaligned");
    a_fh_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fh[2:0] == 3'b000)
        else $error("free list head misaligned");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ost != ST_OK) |-> (r_opay == '0))
        else $error("failed request returned an address");
endmodule

@@ rtl/core/first_fit_free_list_allocator_top.sv @@
// First-fit free list allocator, top level: request/response channels and config.
// Depends on ffa_pkg, ffa_if, ffa_ctrl, ffa_dp and ffa_ram.
// One transaction at a time, one heap word access per cycle; allocate walks the free list
// entry by entry and grows the heap when no entry fits; free walks the heap block by block.
// The next request is accepted in the cycle after the result issues.
// Reset (synchronous, active low) runs a heap setup with ready low.
module first_fit_free_list_allocator_top #(
    parameter int unsigned HEAP_BYTES       = 65536,
    parameter int unsigned INIT_CHUNK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    ffa_req_if.sink     i_req,
    ffa_rsp_if.source   o_rsp
);
    import ffa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ffa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_req.valid),
        .o_in_ready(i_req.ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ffa_dp #(
        .HEAP_BYTES      (HEAP_BYTES),
        .INIT_CHUNK_BYTES(INIT_CHUNK_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_req.func),
        .i_request_bytes(i_req.request_bytes),
        .i_block_addr   (i_req.block_addr),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_payload_addr (o_rsp.payload_addr),
        .o_status       (o_rsp.status)
    );
endmodule
